@@ src/fcm_pkg.sv @@
// Shared constants, types, quarter-wave sine table and arithmetic helpers for the color map.
package fcm_pkg;

   localparam int FRACTION_BITS    = 16;
   localparam int COLOR_BITS       = 8;
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH);
   localparam int SINE_INDEX_BITS  = SINE_ADDR_BITS + 2;
   localparam int SINE_ENTRY_BITS  = 17;
   localparam int SINE_FRAC_BITS   = 16;
   localparam int LIFT_BITS        = SINE_FRAC_BITS + 2;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 16;
   localparam int DIV10_SHIFT      = FRACTION_BITS + 8;
   localparam int DIV10_MUL_BITS   = DIV10_SHIFT - 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PALETTE_SELECT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_SHIFT    = 2'd1;

   typedef enum logic [2:0] {
      PAL_RAINBOW  = 3'd0,
      PAL_FIRE     = 3'd1,
      PAL_ELECTRIC = 3'd2,
      PAL_TWILIGHT = 3'd3,
      PAL_NEON     = 3'd4,
      PAL_SEPIA    = 3'd5
   } palette_type;

   typedef logic [FRACTION_BITS-1:0]   phase_type;
   typedef logic [FRACTION_BITS:0]     half_phase_type;
   typedef logic [FRACTION_BITS+2:0]   lin_type;
   typedef logic [FRACTION_BITS+3:0]   dividend_type;
   typedef logic [COLOR_BITS-1:0]      color_type;
   typedef logic [SINE_INDEX_BITS-1:0] sine_index_type;
   typedef logic [LIFT_BITS-1:0]       lift_type;
   typedef logic [SINE_TABLE_DEPTH:0][SINE_ENTRY_BITS-1:0] sine_table_type;

   localparam logic [63:0] PHASE_ONE   = 64'd1 << FRACTION_BITS;
   localparam logic [63:0] SINE_ONE    = 64'd1 << SINE_FRAC_BITS;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // circle offsets rounded to the nearest phase step
   localparam phase_type      THIRD        = phase_type'((2 * PHASE_ONE + 3) / 6);
   localparam phase_type      TWO_THIRDS   = phase_type'((4 * PHASE_ONE + 3) / 6);
   localparam phase_type      POINT_THREE  = phase_type'((3 * PHASE_ONE + 5) / 10);
   localparam half_phase_type NEON_QUARTER = half_phase_type'(PHASE_ONE >> 1);
   localparam half_phase_type NEON_SIXTH   = half_phase_type'((2 * PHASE_ONE + 3) / 6);

   localparam logic [DIV10_MUL_BITS-1:0] DIV10_MUL =
      DIV10_MUL_BITS'(((64'd1 << DIV10_SHIFT) + 9) / 10);

   // Quarter-wave sine in Q1.16 from a seven-term Taylor series in Q2.30.
   function automatic sine_table_type build_sine();
      sine_table_type tab;
      logic [63:0]    x;
      logic [63:0]    x2;
      logic [63:0]    term;
      logic [63:0]    sum;
      logic [63:0]    q;
      tab = '0;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n[0]) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         q = (sum + (64'd1 << 13)) >> 14;
         if (q > SINE_ONE) begin
            q = SINE_ONE;
         end
         tab[i] = q[SINE_ENTRY_BITS-1:0];
      end
      return tab;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine();

   // (sin + 1) in Q2.16 for a full-circle index; quadrants mirror the table.
   function automatic lift_type lift_at(input sine_index_type idx);
      logic [1:0]                quad;
      logic [SINE_ADDR_BITS:0]   addr;
      logic [SINE_ENTRY_BITS-1:0] t;
      quad = idx[SINE_INDEX_BITS-1 -: 2];
      addr = quad[0] ? ((SINE_ADDR_BITS+1)'(SINE_TABLE_DEPTH)
                        - {1'b0, idx[SINE_ADDR_BITS-1:0]})
                     : {1'b0, idx[SINE_ADDR_BITS-1:0]};
      t    = SINE_TABLE[addr];
      return quad[1] ? (lift_type'(SINE_ONE) - lift_type'(t))
                     : (lift_type'(SINE_ONE) + lift_type'(t));
   endfunction

   // min(v, 1.0) from Q3.16 to a color code, rounded to nearest.
   function automatic color_type lin_code(input lin_type v);
      logic [FRACTION_BITS:0]            vc;
      logic [FRACTION_BITS+COLOR_BITS:0] wide;
      logic [FRACTION_BITS+COLOR_BITS:0] prod;
      vc   = (v > lin_type'(PHASE_ONE)) ? (FRACTION_BITS+1)'(PHASE_ONE)
                                        : v[FRACTION_BITS:0];
      wide = (FRACTION_BITS+COLOR_BITS+1)'(vc);
      prod = (wide << COLOR_BITS) - wide
           + ((FRACTION_BITS+COLOR_BITS+1)'(1) << (FRACTION_BITS-1));
      return prod[FRACTION_BITS+COLOR_BITS-1:FRACTION_BITS];
   endfunction

   // min(1.5 * (sin+1)/2, 1.0) to a color code.
   function automatic color_type rainbow_code(input lift_type lift);
      logic [LIFT_BITS+1:0]            m;
      logic [LIFT_BITS:0]              mc;
      logic [LIFT_BITS+COLOR_BITS:0]   wide;
      logic [LIFT_BITS+COLOR_BITS:0]   prod;
      m    = (LIFT_BITS+2)'(lift) + (LIFT_BITS+2)'({lift, 1'b0});
      mc   = (m > ((LIFT_BITS+2)'(1) << LIFT_BITS)) ? ((LIFT_BITS+1)'(1) << LIFT_BITS)
                                                     : m[LIFT_BITS:0];
      wide = (LIFT_BITS+COLOR_BITS+1)'(mc);
      prod = (wide << COLOR_BITS) - wide
           + ((LIFT_BITS+COLOR_BITS+1)'(1) << (LIFT_BITS-1));
      return prod[LIFT_BITS+COLOR_BITS-1:LIFT_BITS];
   endfunction

   // (sin+1)/2 to a color code.
   function automatic color_type neon_code(input lift_type lift);
      logic [LIFT_BITS+COLOR_BITS-1:0] wide;
      logic [LIFT_BITS+COLOR_BITS-1:0] prod;
      wide = (LIFT_BITS+COLOR_BITS)'(lift);
      prod = (wide << COLOR_BITS) - wide
           + ((LIFT_BITS+COLOR_BITS)'(1) << (LIFT_BITS-2));
      return prod[LIFT_BITS+COLOR_BITS-2:LIFT_BITS-1];
   endfunction

   // floor(x / 10) by reciprocal multiply; exact for x below 2^(FRACTION_BITS+4).
   function automatic half_phase_type div10(input dividend_type x);
      logic [FRACTION_BITS+4+DIV10_MUL_BITS-1:0] prod;
      prod = (FRACTION_BITS+4+DIV10_MUL_BITS)'(x)
           * (FRACTION_BITS+4+DIV10_MUL_BITS)'(DIV10_MUL);
      return prod[DIV10_SHIFT +: FRACTION_BITS+1];
   endfunction

endpackage

@@ src/fractal_palette_color_map.sv @@
// Top level: register-selected six-palette color map from escape value to RGB.
// An accepted item passes the input register, then the result register, before it shows on rsp_*.
// Throughput: one transaction per clock; busy is low except during reset.
// Work sits between the input register and the result register: phase add,
// one quarter-sine table read per channel and the color scaling multiply.
// Reset: synchronous, clears the valid stages, palette_select and phase_shift to 0;
// the sine table is constant logic, so no fill pass; the receiver cannot stall.
module fractal_palette_color_map
   import fcm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [FRACTION_BITS-1:0]  req_norm_iter,
   output logic                      rsp_valid,
   output logic [COLOR_BITS-1:0]     rsp_red,
   output logic [COLOR_BITS-1:0]     rsp_green,
   output logic [COLOR_BITS-1:0]     rsp_blue,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // configuration registers
   palette_type palette_ff;
   phase_type   shift_ff;

   // input stage
   logic        req_valid_ff;
   phase_type   norm_ff;

   // result stage
   logic        rsp_valid_ff;
   color_type   red_ff;
   color_type   green_ff;
   color_type   blue_ff;
   color_type   red_in;
   color_type   green_in;
   color_type   blue_in;

   logic           accept;
   logic           is_rainbow;
   phase_type      tripled;
   phase_type      phase;
   phase_type      rb_phase_r;
   phase_type      rb_phase_g;
   phase_type      rb_phase_b;
   half_phase_type ne_phase_r;
   half_phase_type ne_phase_g;
   half_phase_type ne_phase_b;
   sine_index_type idx_r;
   sine_index_type idx_g;
   sine_index_type idx_b;
   lift_type       lift_r;
   lift_type       lift_g;
   lift_type       lift_b;
   lin_type        two_p;
   lin_type        three_half_p;
   lin_type        five_half_p;
   lin_type        fire_green;

   // hold off new transactions only while reset is applied
   assign busy   = reset;
   assign accept = start && !busy;

   // register writes; an index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff <= PAL_RAINBOW;
         shift_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PALETTE_SELECT: palette_ff <= palette_type'(csr_wdata[2:0]);
            CSR_PHASE_SHIFT:    shift_ff   <= csr_wdata[FRACTION_BITS-1:0];
            default:            ;
         endcase
      end
   end

   // capture the accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
      if (accept) begin
         norm_ff <= req_norm_iter;
      end
   end

   // phase: rainbow triples the value to run three color circles per unit; the others take it as is
   assign is_rainbow = (palette_ff == PAL_RAINBOW);
   assign tripled    = phase_type'((FRACTION_BITS+1)'({norm_ff, 1'b0})
                                   + (FRACTION_BITS+1)'(norm_ff));
   assign phase      = (is_rainbow ? tripled : norm_ff) + shift_ff;

   // rainbow channels sit a third of a circle apart and wrap modulo one
   assign rb_phase_r = phase;
   assign rb_phase_g = phase + THIRD;
   assign rb_phase_b = phase + TWO_THIRDS;

   // neon uses half a circle per unit, so its angle carries one more bit
   assign ne_phase_r = half_phase_type'(phase);
   assign ne_phase_g = half_phase_type'(phase) + NEON_QUARTER;
   assign ne_phase_b = half_phase_type'(phase) + NEON_SIXTH;

   // one table read per channel, shared by rainbow and neon
   assign idx_r = is_rainbow ? rb_phase_r[FRACTION_BITS-1 -: SINE_INDEX_BITS]
                             : ne_phase_r[FRACTION_BITS -: SINE_INDEX_BITS];
   assign idx_g = is_rainbow ? rb_phase_g[FRACTION_BITS-1 -: SINE_INDEX_BITS]
                             : ne_phase_g[FRACTION_BITS -: SINE_INDEX_BITS];
   assign idx_b = is_rainbow ? rb_phase_b[FRACTION_BITS-1 -: SINE_INDEX_BITS]
                             : ne_phase_b[FRACTION_BITS -: SINE_INDEX_BITS];

   assign lift_r = lift_at(idx_r);
   assign lift_g = lift_at(idx_g);
   assign lift_b = lift_at(idx_b);

   // linear ramps, truncated like the integer products p*n/10
   assign two_p        = lin_type'({phase, 1'b0});
   assign three_half_p = (lin_type'(phase) * lin_type'(3)) >> 1;
   assign five_half_p  = (lin_type'(phase) * lin_type'(5)) >> 1;
   assign fire_green   = lin_type'({phase_type'(phase - POINT_THREE), 1'b0});

   // palette select; unused codes give black
   always_comb begin
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      case (palette_ff)
         PAL_RAINBOW: begin
            red_in   = rainbow_code(lift_r);
            green_in = rainbow_code(lift_g);
            blue_in  = rainbow_code(lift_b);
         end
         PAL_FIRE: begin
            red_in   = lin_code(two_p);
            green_in = (phase > POINT_THREE) ? lin_code(fire_green) : '0;
         end
         PAL_ELECTRIC: begin
            green_in = lin_code(two_p);
            blue_in  = lin_code(five_half_p);
         end
         PAL_TWILIGHT: begin
            red_in   = lin_code(three_half_p);
            blue_in  = lin_code(two_p);
         end
         PAL_NEON: begin
            red_in   = neon_code(lift_r);
            green_in = neon_code(lift_g);
            blue_in  = neon_code(lift_b);
         end
         PAL_SEPIA: begin
            red_in   = lin_code(lin_type'(div10(dividend_type'(phase) * dividend_type'(12))));
            green_in = lin_code(lin_type'(div10(dividend_type'(phase) * dividend_type'(11))));
            blue_in  = lin_code(lin_type'(div10(dividend_type'(phase) * dividend_type'(9))));
         end
         default: begin
            red_in   = '0;
            green_in = '0;
            blue_in  = '0;
         end
      endcase
   end

   // result register: strobe for exactly one cycle per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      if (req_valid_ff) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

@@ tb/sv/fractal_palette_color_map_test.sv @@
// Self-checking testbench for the palette color map: directed and random pixels with a scoreboard.
module fractal_palette_color_map_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fcm_pkg::*;

   // Fixed-point constants used by the pixel predictor
   localparam logic [63:0] PHASE_UNIT      = 64'd1 << FRACTION_BITS;
   localparam logic [63:0] PHASE_BITS_MASK = PHASE_UNIT - 64'd1;
   localparam logic [63:0] CODE_MAX        = (64'd1 << COLOR_BITS) - 64'd1;
   localparam logic [63:0] SINE_UNIT       = 64'd65536;
   localparam logic [63:0] HALF_PI_Q2_30   = 64'd1686629713;
   // a third and two thirds of a circle, rounded to the nearest phase step
   localparam logic [63:0] OFS_THIRD       = (64'd2 * PHASE_UNIT + 64'd3) / 64'd6;
   localparam logic [63:0] OFS_TWO_THIRDS  = (64'd4 * PHASE_UNIT + 64'd3) / 64'd6;
   // fire green starts at 0.3
   localparam logic [63:0] FIRE_KNEE       = (64'd3 * PHASE_UNIT + 64'd5) / 64'd10;
   // neon angles are pi*p, so the circle holds 2^(FRACTION_BITS+1) steps
   localparam logic [63:0] NEON_HALF       = PHASE_UNIT >> 1;
   localparam logic [63:0] NEON_SIXTH      = (64'd2 * PHASE_UNIT + 64'd3) / 64'd6;

   // Palette codes past the last palette map to black
   localparam logic [2:0] PAL_UNUSED_HI = 3'd7;
   // Register indexes with no register behind them
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;

   localparam int RESULT_LATENCY  = 2;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_PHASES   = 24;
   localparam int ITEMS_PER_PHASE = 50;

   typedef struct packed {
      color_type red;
      color_type green;
      color_type blue;
   } rgb_pixel_type;

   // Mirrors the two registers, predicts each pixel and holds the pixels still to come.
   class pixel_scoreboard;
      rgb_pixel_type expected_pixels[$];
      logic [2:0]    palette;
      phase_type     shift;
      int            quarter_sine[SINE_TABLE_DEPTH+1];
      int            mismatches;
      int            values_seen;
      int            pixels_checked;

      function new();
         logic [63:0] x;
         logic [63:0] x2;
         logic [63:0] term;
         logic [63:0] sum;
         logic [63:0] q;
         palette        = '0;
         shift          = '0;
         mismatches     = 0;
         values_seen    = 0;
         pixels_checked = 0;
         // quarter-wave table: Taylor series in Q2.30, truncated each step, rounded to Q1.16
         for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (64'(i) * HALF_PI_Q2_30) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 6; n++) begin
               term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
               if (n % 2 == 1) begin
                  sum = (sum >= term) ? sum - term : 64'd0;
               end else begin
                  sum = sum + term;
               end
            end
            q = (sum + (64'd1 << 13)) >> 14;
            if (q > SINE_UNIT) begin
               q = SINE_UNIT;
            end
            quarter_sine[i] = int'(q);
         end
      endfunction

      function void write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_PALETTE_SELECT: palette = data[2:0];
            CSR_PHASE_SHIFT:    shift   = data[FRACTION_BITS-1:0];
            default: ;
         endcase
      endfunction

      // sine in Q1.16 of a circle fraction with fbits fraction bits
      function int sine_q16(logic [63:0] frac, int fbits);
         logic [63:0] mask;
         logic [63:0] idx;
         logic [63:0] quad;
         logic [63:0] r;
         mask = (64'd1 << fbits) - 64'd1;
         idx  = ((frac & mask) * 64'(4 * SINE_TABLE_DEPTH)) >> fbits;
         quad = (idx / 64'(SINE_TABLE_DEPTH)) & 64'd3;
         r    = idx % 64'(SINE_TABLE_DEPTH);
         case (quad)
            64'd0:   return quarter_sine[r];
            64'd1:   return quarter_sine[SINE_TABLE_DEPTH - r];
            64'd2:   return -quarter_sine[r];
            default: return -quarter_sine[SINE_TABLE_DEPTH - r];
         endcase
      endfunction

      function color_type to_code(logic [63:0] x, int bits);
         return color_type'(((x * CODE_MAX + (64'd1 << (bits - 1))) >> bits) & CODE_MAX);
      endfunction

      // min(p * tenths / 10, 1) as a color code
      function color_type ramp_code(logic [63:0] p, int tenths);
         logic [63:0] v;
         v = (p * 64'(tenths)) / 64'd10;
         if (v > PHASE_UNIT) begin
            v = PHASE_UNIT;
         end
         return to_code(v, FRACTION_BITS);
      endfunction

      // min(1.5 * (sin + 1) / 2, 1); (sin + 1) is Q2.16, times three gives Q.18
      function color_type rainbow_level(logic [63:0] p);
         logic [63:0] m;
         m = 64'(sine_q16(p, FRACTION_BITS) + int'(SINE_UNIT)) * 64'd3;
         if (m > (64'd1 << 18)) begin
            m = 64'd1 << 18;
         end
         return to_code(m, 18);
      endfunction

      function color_type neon_level(logic [63:0] p);
         return to_code(64'(sine_q16(p, FRACTION_BITS + 1) + int'(SINE_UNIT)), 17);
      endfunction

      function rgb_pixel_type map_pixel(phase_type value);
         logic [63:0]   v;
         logic [63:0]   k;
         logic [63:0]   p;
         rgb_pixel_type px;
         v  = 64'(value) & PHASE_BITS_MASK;
         k  = (palette == PAL_RAINBOW) ? 64'd3 : 64'd1;
         p  = (k * v + 64'(shift)) & PHASE_BITS_MASK;
         px = '0;
         case (palette)
            PAL_RAINBOW: begin
               px.red   = rainbow_level(p);
               px.green = rainbow_level(p + OFS_THIRD);
               px.blue  = rainbow_level(p + OFS_TWO_THIRDS);
            end
            PAL_FIRE: begin
               px.red   = ramp_code(p, 20);
               px.green = (p > FIRE_KNEE) ? ramp_code(p - FIRE_KNEE, 20) : '0;
            end
            PAL_ELECTRIC: begin
               px.green = ramp_code(p, 20);
               px.blue  = ramp_code(p, 25);
            end
            PAL_TWILIGHT: begin
               px.red  = ramp_code(p, 15);
               px.blue = ramp_code(p, 20);
            end
            PAL_NEON: begin
               px.red   = neon_level(p);
               px.green = neon_level(p + NEON_HALF);
               px.blue  = neon_level(p + NEON_SIXTH);
            end
            PAL_SEPIA: begin
               px.red   = ramp_code(p, 12);
               px.green = ramp_code(p, 11);
               px.blue  = ramp_code(p, 9);
            end
            default: ;
         endcase
         return px;
      endfunction

      function void note_value(phase_type value);
         expected_pixels.push_back(map_pixel(value));
         values_seen++;
      endfunction

      function void check_pixel(color_type red, color_type green, color_type blue);
         rgb_pixel_type want;
         pixels_checked++;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected pixel r=%0d g=%0d b=%0d at %0t", red, green, blue, $realtime);
            end
            return;
         end
         want = expected_pixels.pop_front();
         if (want.red !== red || want.green !== green || want.blue !== blue) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("pixel mismatch at %0t: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                        $realtime, want.red, want.green, want.blue, red, green, blue);
            end
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   phase_type                 req_norm_iter;
   logic                      rsp_valid;
   color_type                 rsp_red;
   color_type                 rsp_green;
   color_type                 rsp_blue;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   pixel_scoreboard board;
   int              cycle_count = 0;

   fractal_palette_color_map u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_norm_iter (req_norm_iter),
      .rsp_valid     (rsp_valid),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Watchdog: give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[fractal_palette_color_map] ERROR");
         $finish;
      end
   end

   // Monitor at the rising edge: check a strobed pixel, and note each accepted transaction.
   // Pre-edge values are read here, so the order against the block's own updates does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            board.check_pixel(rsp_red, rsp_green, rsp_blue);
         end
         if (start && !busy) begin
            board.note_value(req_norm_iter);
         end
      end
   end

   // Present one value at the falling edge and hold it until the block takes it.
   task automatic send_value(phase_type value);
      @(negedge clock);
      start         <= 1'b1;
      req_norm_iter <= value;
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   // Drop start for the given number of cycles; scramble the idle data meanwhile.
   task automatic hold_off(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start         <= 1'b0;
         req_norm_iter <= phase_type'($urandom);
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Stop sending and wait until every predicted pixel has come back, then let the pipe settle.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 2) @(posedge clock);
   endtask

   // One register write; mirror it into the scoreboard at the edge that takes it.
   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      board.write_csr(idx, data);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Mostly uniform values, with the ends of the range and the fire knee mixed in.
   function automatic phase_type pick_value();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return phase_type'(FIRE_KNEE - 64'd1 + 64'($urandom_range(0, 2)));
         3:       return phase_type'($urandom_range(0, 15));
         4:       return phase_type'(16'hFFFF - 16'($urandom_range(0, 15)));
         default: return phase_type'($urandom);
      endcase
   endfunction

   // Mostly back-to-back, some short gaps, a few long ones; none in steady stretches.
   function automatic int pick_gap(bit steady);
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) begin
         return 0;
      end else if (roll < 88) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   initial begin
      logic [2:0]               pal_code;
      logic [CSR_DATA_BITS-1:0] shift_word;
      bit                       steady;
      int                       leftover;

      board         = new();
      reset         = 1'b1;
      start         = 1'b0;
      req_norm_iter = '0;
      csr_write_en  = 1'b0;
      csr_index     = CSR_PALETTE_SELECT;
      csr_wdata     = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: rainbow out of reset at both ends and at a third of the range.
      send_value('0);
      send_value('1);
      send_value(phase_type'(OFS_THIRD));

      // Directed: every other palette code, including the two that give black.
      for (int c = PAL_FIRE; c <= PAL_UNUSED_HI; c++) begin
         drain();
         // set the spare bits on the last code; only the low three count
         write_reg(CSR_PALETTE_SELECT, (c == PAL_UNUSED_HI) ? 16'hFFFF : CSR_DATA_BITS'(c));
         if (c == PAL_NEON) begin
            // full shift wraps the phase; spare indexes must leave the registers alone
            write_reg(CSR_PHASE_SHIFT, 16'hFFFF);
            write_reg(CSR_SPARE_A, 16'hFFFF);
            write_reg(CSR_SPARE_B, 16'h0000);
         end
         send_value('0);
         send_value('1);
         send_value(phase_type'(FIRE_KNEE + 64'd1));
      end

      // Random phases: reconfigure while idle, then stream values with random gaps.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain();
         pal_code = (ph < 18) ? 3'(ph % 6) : 3'($urandom_range(0, 7));
         case (ph % 4)
            0:       shift_word = '0;
            1:       shift_word = '1;
            default: shift_word = CSR_DATA_BITS'($urandom);
         endcase
         if ($urandom_range(0, 1) == 0) begin
            write_reg(CSR_PALETTE_SELECT, {13'($urandom), pal_code});
            write_reg(CSR_PHASE_SHIFT, shift_word);
         end else begin
            write_reg(CSR_PHASE_SHIFT, shift_word);
            write_reg(CSR_PALETTE_SELECT, {13'($urandom), pal_code});
         end
         if (ph % 5 == 2) begin
            write_reg(($urandom_range(0, 1) == 0) ? CSR_SPARE_A : CSR_SPARE_B,
                      CSR_DATA_BITS'($urandom));
         end
         steady = (ph % 3 == 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_value(pick_value());
            // pause now and then until the pipe is empty
            if ((ph == 3 && n == ITEMS_PER_PHASE / 2) || $urandom_range(0, 199) == 0) begin
               drain();
            end else begin
               hold_off(pick_gap(steady));
            end
         end
      end

      drain();
      leftover = board.pending();
      if (leftover != 0) begin
         $display("%0d predicted pixels never arrived", leftover);
      end
      $display("Covered %0d transactions over all eight palette codes,", board.values_seen);
      $display("with zero, full and random shifts; %0d pixels compared, %0d mismatches.",
               board.pixels_checked, board.mismatches);
      if (board.mismatches == 0 && leftover == 0) begin
         $display("[fractal_palette_color_map] OK");
      end else begin
         $display("[fractal_palette_color_map] ERROR");
      end
      $finish;
   end

endmodule

@@ fractal_palette_color_map.f @@
src/fcm_pkg.sv
src/fractal_palette_color_map.sv
tb/sv/fractal_palette_color_map_test.sv
